// File: design/lu_cholesky_factorizer_core_macros.svh
// Assertion macros used by the factorizer controller.
`ifndef LU_CHOLESKY_FACTORIZER_CORE_MACROS_SVH
`define LU_CHOLESKY_FACTORIZER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LUCF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LUCF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/lucf_pkg.sv
// Shared types and constants of the LU / Cholesky factorizer.
package lucf_pkg;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;
	localparam int SIZE_W  = 4;
	localparam int FLAT_W  = 6;
	localparam int COUNT_W = 7;
	localparam int CFG_W   = 4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_PIV = 2'd1;
	localparam logic [1:0] STATUS_NEG_DIAG = 2'd2;
	localparam logic [1:0] STATUS_SAT      = 2'd3;

	localparam logic REG_MATRIX_SIZE = 1'b0;
	localparam logic REG_FACTOR_MODE = 1'b1;

	typedef enum logic [1:0] {
		WS_LOAD,
		WS_SQRT,
		WS_DIV,
		WS_UPD
	} wsel_t;

	typedef enum logic [2:0] {
		LT_NONE,
		LT_A,
		LT_B,
		LT_ACC,
		LT_PIV
	} lat_t;

	typedef struct packed {
		logic              rd;
		logic              wr;
		wsel_t             wsel;
		lat_t              lat;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              use_flat;
		logic [FLAT_W-1:0] flat;
		logic              sqrt_go;
		logic              div_go;
		logic              mul_go;
		logic              clr_status;
		logic              emit;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
	} stat_t;

endpackage

// File: design/lucf_div.sv
// Iterative signed fixed-point divider: (a * 2^F) / p, one quotient bit per cycle.
module lucf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic signed [lucf_pkg::DATA_W-1:0] a,
	input  logic signed [lucf_pkg::DATA_W-1:0] p,
	output logic signed [lucf_pkg::DATA_W-1:0] result,
	output logic                             zero_piv,
	output logic                             sat,
	output logic                             done
);
	localparam int DW = lucf_pkg::DATA_W + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam logic [DW-1:0] POS_LIM = DW'(32'h7FFF_FFFF);
	localparam logic [DW-1:0] NEG_LIM = DW'(33'h0_8000_0000);

	logic [lucf_pkg::DATA_W:0]   rem_q;
	logic [DW-1:0]               num_q;
	logic [lucf_pkg::DATA_W-1:0] den_q;
	logic [CW-1:0]               cnt_q;
	logic                        run_q;
	logic                        fin_q;
	logic                        neg_q;
	logic [lucf_pkg::DATA_W:0]   trial;
	logic                        take;
	logic [lucf_pkg::DATA_W-1:0] a_mag;
	logic [lucf_pkg::DATA_W-1:0] p_mag;

	// Form magnitudes and the next restoring step
	always_comb begin
		a_mag = a[lucf_pkg::DATA_W-1] ? (~a + 1'b1) : a;
		p_mag = p[lucf_pkg::DATA_W-1] ? (~p + 1'b1) : p;
		trial = {rem_q[lucf_pkg::DATA_W-1:0], num_q[DW-1]};
		take  = trial >= {1'b0, den_q};
	end

	// Flag a zero pivot at once, else run the shift-subtract loop, then sign and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			fin_q    <= 1'b0;
			done     <= 1'b0;
			cnt_q    <= '0;
			rem_q    <= '0;
			num_q    <= '0;
			den_q    <= '0;
			neg_q    <= 1'b0;
			result   <= '0;
			zero_piv <= 1'b0;
			sat      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				if (p == '0) begin
					result   <= '0;
					zero_piv <= 1'b1;
					sat      <= 1'b0;
					done     <= 1'b1;
				end else begin
					rem_q    <= '0;
					num_q    <= {a_mag, {FRAC_BITS{1'b0}}};
					den_q    <= p_mag;
					neg_q    <= a[lucf_pkg::DATA_W-1] ^ p[lucf_pkg::DATA_W-1];
					cnt_q    <= CW'(DW);
					run_q    <= 1'b1;
					zero_piv <= 1'b0;
				end
			end else if (run_q) begin
				rem_q <= take ? (trial - {1'b0, den_q}) : trial;
				num_q <= {num_q[DW-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
				done  <= 1'b1;
				if (!neg_q && num_q > POS_LIM) begin
					result <= 32'sh7FFF_FFFF;
					sat    <= 1'b1;
				end else if (neg_q && num_q > NEG_LIM) begin
					result <= 32'sh8000_0000;
					sat    <= 1'b1;
				end else begin
					result <= neg_q ? -$signed(num_q[lucf_pkg::DATA_W-1:0])
						: $signed(num_q[lucf_pkg::DATA_W-1:0]);
					sat    <= 1'b0;
				end
			end
		end
	end
endmodule

// File: design/lucf_sqrt.sv
// Iterative integer square root of a * 2^F, two radicand bits per cycle.
module lucf_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic signed [lucf_pkg::DATA_W-1:0] a,
	output logic signed [lucf_pkg::DATA_W-1:0] result,
	output logic                               non_pos,
	output logic                               done
);
	localparam int RW = lucf_pkg::DATA_W + FRAC_BITS;
	localparam int RW2 = RW + (RW % 2);
	localparam int R = RW2 / 2;
	localparam int CW = $clog2(R + 1);

	logic [RW2-1:0] rad_q;
	logic [R+1:0]   rem_q;
	logic [R-1:0]   root_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic [R+1:0]   rem_n;
	logic [R+1:0]   trial;
	logic           take;

	// Bring down two radicand bits and try the next root bit
	always_comb begin
		rem_n = {rem_q[R-1:0], rad_q[RW2-1:RW2-2]};
		trial = {root_q, 2'b01};
		take  = rem_n >= trial;
	end

	// Flag a non-positive radicand at once, else step the root one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done    <= 1'b0;
			cnt_q   <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			result  <= '0;
			non_pos <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				if (a[lucf_pkg::DATA_W-1] || a == '0) begin
					result  <= '0;
					non_pos <= 1'b1;
					done    <= 1'b1;
				end else begin
					rad_q   <= RW2'({a, {FRAC_BITS{1'b0}}});
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= CW'(R);
					run_q   <= 1'b1;
					non_pos <= 1'b0;
				end
			end else if (run_q) begin
				rad_q  <= {rad_q[RW2-3:0], 2'b00};
				rem_q  <= take ? (rem_n - trial) : rem_n;
				root_q <= {root_q[R-2:0], take};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done   <= 1'b1;
					result <= $signed(lucf_pkg::DATA_W'({root_q[R-2:0], take}));
				end
			end
		end
	end
endmodule

// File: design/lucf_datapath.sv
// Datapath: matrix memory, operand registers, multiply-update, divider, root, outputs.
module lucf_datapath #(
	parameter int MAX_ORDER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lucf_pkg::cmd_t                     cmd,
	output lucf_pkg::stat_t                    stat,
	input  logic [lucf_pkg::SIZE_W-1:0]        order_n,
	input  logic signed [lucf_pkg::DATA_W-1:0] element_value,
	output logic                               result_strobe,
	output logic signed [lucf_pkg::DATA_W-1:0] factor_value,
	output logic [lucf_pkg::IDX_W-1:0]         row_index,
	output logic [lucf_pkg::IDX_W-1:0]         col_index,
	output logic [1:0]                         status_code,
	output logic                               last_of_run
);
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = 2 * lucf_pkg::DATA_W;
	localparam logic signed [PW+1:0] HALF = (PW+2)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PW+1:0] SMAX = (PW+2)'(32'sh7FFF_FFFF);
	localparam logic signed [PW+1:0] SMIN = -((PW+2)'(33'sh0_8000_0000));

	logic signed [lucf_pkg::DATA_W-1:0] mem [DEPTH];
	logic signed [lucf_pkg::DATA_W-1:0] rdata_q;
	logic signed [lucf_pkg::DATA_W-1:0] a_q, b_q, acc_q, piv_q;
	logic signed [PW-1:0]               prod_q;
	lucf_pkg::lat_t                     lat_s1;
	logic [1:0]                         status_q;
	logic [lucf_pkg::COUNT_W-1:0]       full_addr;
	logic [AW-1:0]                      addr;
	logic signed [PW+1:0]               rounded;
	logic signed [PW+1:0]               diff;
	logic signed [lucf_pkg::DATA_W-1:0] upd_val;
	logic                               upd_sat;
	logic signed [lucf_pkg::DATA_W-1:0] wdata;
	logic [1:0]                         fault;
	logic signed [lucf_pkg::DATA_W-1:0] div_res, sqrt_res;
	logic                               div_zero, div_sat, div_done;
	logic                               sqrt_neg, sqrt_done;

	lucf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go), .a(a_q), .p(piv_q),
		.result(div_res), .zero_piv(div_zero), .sat(div_sat), .done(div_done)
	);

	lucf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(cmd.sqrt_go), .a(a_q),
		.result(sqrt_res), .non_pos(sqrt_neg), .done(sqrt_done)
	);

	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;

	// Map row and column to a row-major address with stride n
	always_comb begin
		full_addr = lucf_pkg::COUNT_W'(cmd.row) * lucf_pkg::COUNT_W'(order_n)
			+ lucf_pkg::COUNT_W'(cmd.col);
		addr = cmd.use_flat ? cmd.flat[AW-1:0] : full_addr[AW-1:0];
	end

	// Round the product, subtract it and saturate
	always_comb begin
		rounded = ((PW+2)'(prod_q) + HALF) >>> FRAC_BITS;
		diff    = (PW+2)'(acc_q) - rounded;
		upd_sat = (diff > SMAX) || (diff < SMIN);
		if (diff > SMAX) begin
			upd_val = 32'sh7FFF_FFFF;
		end else if (diff < SMIN) begin
			upd_val = 32'sh8000_0000;
		end else begin
			upd_val = diff[lucf_pkg::DATA_W-1:0];
		end
	end

	// Select write data and the fault it raises
	always_comb begin
		wdata = element_value;
		fault = lucf_pkg::STATUS_OK;
		case (cmd.wsel)
			lucf_pkg::WS_LOAD: wdata = element_value;
			lucf_pkg::WS_SQRT: begin
				wdata = sqrt_res;
				if (sqrt_neg) fault = lucf_pkg::STATUS_NEG_DIAG;
			end
			lucf_pkg::WS_DIV: begin
				wdata = div_res;
				if (div_zero) fault = lucf_pkg::STATUS_ZERO_PIV;
				else if (div_sat) fault = lucf_pkg::STATUS_SAT;
			end
			lucf_pkg::WS_UPD: begin
				wdata = upd_val;
				if (upd_sat) fault = lucf_pkg::STATUS_SAT;
			end
			default: wdata = element_value;
		endcase
	end

	// Write and read the matrix memory
	always_ff @(posedge clk) begin
		if (cmd.wr) mem[addr] <= wdata;
		if (cmd.rd) rdata_q <= mem[addr];
	end

	// Latch operands from the registered read data, steered by the delayed target, and multiply
	always_ff @(posedge clk) begin
		case (lat_s1)
			lucf_pkg::LT_A:   a_q   <= rdata_q;
			lucf_pkg::LT_B:   b_q   <= rdata_q;
			lucf_pkg::LT_ACC: acc_q <= rdata_q;
			lucf_pkg::LT_PIV: piv_q <= rdata_q;
			default: ;
		endcase
		if (cmd.mul_go) prod_q <= a_q * b_q;
	end

	// Track the operand target, the run status and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_s1        <= lucf_pkg::LT_NONE;
			status_q      <= lucf_pkg::STATUS_OK;
			result_strobe <= 1'b0;
		end else begin
			lat_s1 <= cmd.rd ? cmd.lat : lucf_pkg::LT_NONE;
			if (cmd.clr_status) begin
				status_q <= lucf_pkg::STATUS_OK;
			end else if (cmd.wr && status_q == lucf_pkg::STATUS_OK) begin
				status_q <= fault;
			end
			result_strobe <= cmd.emit;
		end
	end

	// Hold the tags of an emitted entry beside its read data
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_index   <= cmd.row;
			col_index   <= cmd.col;
			status_code <= status_q;
			last_of_run <= cmd.last;
		end
	end

	assign factor_value = rdata_q;
endmodule

// File: design/lucf_ctrl.sv
// Controller: load counting, factorization loop sequencing and emit sweep.
`include "lu_cholesky_factorizer_core_macros.svh"
module lucf_ctrl #(
	parameter int MAX_ORDER = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [lucf_pkg::SIZE_W-1:0] order_n,
	input  logic                        chol,
	output lucf_pkg::cmd_t              cmd,
	input  lucf_pkg::stat_t             stat
);
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;

	typedef enum logic [4:0] {
		ST_IDLE, ST_KBEG, ST_SRD, ST_SLAT, ST_SGO, ST_SWAIT, ST_SWR,
		ST_PRD, ST_PLAT, ST_DCHK, ST_DRD, ST_DLAT, ST_DGO, ST_DWAIT,
		ST_DWR, ST_DWR2, ST_UCHK, ST_URA, ST_URB, ST_URC, ST_UMUL,
		ST_UWR, ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [lucf_pkg::COUNT_W-1:0] lc_q;
	logic [lucf_pkg::SIZE_W-1:0]  k_q, i_q, j_q;
	logic [lucf_pkg::COUNT_W-1:0] total;
	logic [lucf_pkg::COUNT_W-1:0] lc_next;
	logic                         accept;
	logic                         emit_last;
	logic [lucf_pkg::SIZE_W-1:0]  n_m1;

	always_comb begin
		total     = lucf_pkg::COUNT_W'(order_n) * lucf_pkg::COUNT_W'(order_n);
		lc_next   = lc_q + 1'b1;
		accept    = start && (state_q == ST_IDLE);
		n_m1      = order_n - 1'b1;
		emit_last = (i_q == n_m1) && (j_q == n_m1);
	end

	assign busy = (state_q != ST_IDLE);

	// Decode the command for the current step
	always_comb begin
		cmd = '0;
		cmd.wsel = lucf_pkg::WS_LOAD;
		cmd.lat  = lucf_pkg::LT_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.use_flat = 1'b1;
				cmd.flat = lc_q[lucf_pkg::FLAT_W-1:0];
				cmd.wr = accept && (lc_q < lucf_pkg::COUNT_W'(DEPTH));
			end
			ST_SRD: begin
				cmd.rd = 1'b1; cmd.lat = lucf_pkg::LT_A;
				cmd.row = k_q[2:0]; cmd.col = k_q[2:0];
			end
			ST_SGO: cmd.sqrt_go = 1'b1;
			ST_SWR: begin
				cmd.wr = 1'b1; cmd.wsel = lucf_pkg::WS_SQRT;
				cmd.row = k_q[2:0]; cmd.col = k_q[2:0];
			end
			ST_PRD: begin
				cmd.rd = 1'b1; cmd.lat = lucf_pkg::LT_PIV;
				cmd.row = k_q[2:0]; cmd.col = k_q[2:0];
			end
			ST_DRD: begin
				cmd.rd = 1'b1; cmd.lat = lucf_pkg::LT_A;
				cmd.row = i_q[2:0]; cmd.col = k_q[2:0];
			end
			ST_DGO: cmd.div_go = 1'b1;
			ST_DWR: begin
				cmd.wr = 1'b1; cmd.wsel = lucf_pkg::WS_DIV;
				cmd.row = i_q[2:0]; cmd.col = k_q[2:0];
			end
			ST_DWR2: begin
				cmd.wr = 1'b1; cmd.wsel = lucf_pkg::WS_DIV;
				cmd.row = k_q[2:0]; cmd.col = i_q[2:0];
			end
			ST_URA: begin
				cmd.rd = 1'b1; cmd.lat = lucf_pkg::LT_A;
				cmd.row = i_q[2:0]; cmd.col = k_q[2:0];
			end
			ST_URB: begin
				cmd.rd = 1'b1; cmd.lat = lucf_pkg::LT_B;
				cmd.row = chol ? j_q[2:0] : k_q[2:0];
				cmd.col = chol ? k_q[2:0] : j_q[2:0];
			end
			ST_URC: begin
				cmd.rd = 1'b1; cmd.lat = lucf_pkg::LT_ACC;
				cmd.row = i_q[2:0]; cmd.col = j_q[2:0];
			end
			ST_UMUL: cmd.mul_go = 1'b1;
			ST_UWR: begin
				cmd.wr = 1'b1; cmd.wsel = lucf_pkg::WS_UPD;
				cmd.row = i_q[2:0]; cmd.col = j_q[2:0];
			end
			ST_EMIT: begin
				cmd.rd = 1'b1; cmd.emit = 1'b1; cmd.last = emit_last;
				cmd.row = i_q[2:0]; cmd.col = j_q[2:0];
			end
			default: ;
		endcase
		if (state_q == ST_IDLE && accept && lc_next >= total) cmd.clr_status = 1'b1;
	end

	// Advance the loop counters and the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lc_q    <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (lc_next >= total) begin
							lc_q    <= '0;
							k_q     <= '0;
							state_q <= ST_KBEG;
						end else begin
							lc_q <= lc_next;
						end
					end
				end
				ST_KBEG: begin
					if (k_q == order_n) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= chol ? ST_SRD : ST_PRD;
					end
				end
				ST_SRD:   state_q <= ST_SLAT;
				ST_SLAT:  state_q <= ST_SGO;
				ST_SGO:   state_q <= ST_SWAIT;
				ST_SWAIT: if (stat.sqrt_done) state_q <= ST_SWR;
				ST_SWR:   state_q <= ST_PRD;
				ST_PRD:   state_q <= ST_PLAT;
				ST_PLAT: begin
					i_q     <= k_q + 1'b1;
					state_q <= ST_DCHK;
				end
				ST_DCHK: begin
					if (i_q == order_n) begin
						i_q     <= k_q + 1'b1;
						j_q     <= k_q + 1'b1;
						state_q <= ST_UCHK;
					end else begin
						state_q <= ST_DRD;
					end
				end
				ST_DRD:   state_q <= ST_DLAT;
				ST_DLAT:  state_q <= ST_DGO;
				ST_DGO:   state_q <= ST_DWAIT;
				ST_DWAIT: if (stat.div_done) state_q <= ST_DWR;
				ST_DWR: begin
					if (chol) begin
						state_q <= ST_DWR2;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_DCHK;
					end
				end
				ST_DWR2: begin
					i_q     <= i_q + 1'b1;
					state_q <= ST_DCHK;
				end
				ST_UCHK: begin
					if (i_q == order_n) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_KBEG;
					end else if (j_q == order_n) begin
						i_q <= i_q + 1'b1;
						j_q <= k_q + 1'b1;
					end else begin
						state_q <= ST_URA;
					end
				end
				ST_URA:  state_q <= ST_URB;
				ST_URB:  state_q <= ST_URC;
				ST_URC:  state_q <= ST_UMUL;
				ST_UMUL: state_q <= ST_UWR;
				ST_UWR: begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_UCHK;
				end
				ST_EMIT: begin
					if (emit_last) begin
						state_q <= ST_IDLE;
					end else if (j_q == n_m1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LUCF_NEVER(a_rd_wr_excl, cmd.rd && cmd.wr, "memory read and write in one cycle")
	`LUCF_ASSERT(a_sqrt_chol, cmd.sqrt_go |-> chol, "square root started in LU mode")
	`LUCF_ASSERT(a_idle_no_rd, (state_q == ST_IDLE) |-> !cmd.rd, "memory read while idle")
	`LUCF_ASSERT(a_emit_end, (cmd.emit && cmd.last) |=> (state_q == ST_IDLE),
		"emit sweep did not end on the last entry")
endmodule

// File: design/lu_cholesky_factorizer_core.sv
// Loading: one element per cycle while idle; after the last, the block factors the matrix
// with the serial divider and square-root units and one memory port; Cholesky adds a root
// per column and a second write per division.
// Then n*n results follow, one per cycle.
// Throughput: one matrix at a time; start is refused while busy; the receiver cannot stall.
// Reset (arst_n low) clears control state, config to order 8 and LU mode.
module lu_cholesky_factorizer_core #(
	parameter int MAX_ORDER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [lucf_pkg::DATA_W-1:0] element_value,
	input  logic                               write_enable,
	input  logic                               write_index,
	input  logic [lucf_pkg::CFG_W-1:0]         write_data,
	output logic                               result_strobe,
	output logic signed [lucf_pkg::DATA_W-1:0] factor_value,
	output logic [lucf_pkg::IDX_W-1:0]         row_index,
	output logic [lucf_pkg::IDX_W-1:0]         col_index,
	output logic [1:0]                         status_code,
	output logic                               last_of_run
);
	logic [lucf_pkg::SIZE_W-1:0] matrix_size_q;
	logic                        factor_mode_q;
	logic [lucf_pkg::SIZE_W-1:0] order_n;
	lucf_pkg::cmd_t              cmd;
	lucf_pkg::stat_t             stat;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= lucf_pkg::SIZE_W'(8);
			factor_mode_q <= 1'b0;
		end else if (write_enable) begin
			case (write_index)
				lucf_pkg::REG_MATRIX_SIZE: matrix_size_q <= write_data;
				lucf_pkg::REG_FACTOR_MODE: factor_mode_q <= write_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the order into its legal range
	always_comb begin
		if (matrix_size_q == '0) begin
			order_n = lucf_pkg::SIZE_W'(1);
		end else if (matrix_size_q > lucf_pkg::SIZE_W'(MAX_ORDER)) begin
			order_n = lucf_pkg::SIZE_W'(MAX_ORDER);
		end else begin
			order_n = matrix_size_q;
		end
	end

	lucf_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.order_n(order_n), .chol(factor_mode_q), .cmd(cmd), .stat(stat)
	);

	lucf_datapath #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .order_n(order_n),
		.element_value(element_value), .result_strobe(result_strobe),
		.factor_value(factor_value), .row_index(row_index), .col_index(col_index),
		.status_code(status_code), .last_of_run(last_of_run)
	);
endmodule

// File: verif/lu_cholesky_factorizer_core_checker.sv
// Checker for the factorizer: tracks config and loads, predicts each factored matrix, compares.
module lu_cholesky_factorizer_core_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [lucf_pkg::DATA_W-1:0]  element_value,
	input  logic                                write_enable,
	input  logic                                write_index,
	input  logic [lucf_pkg::CFG_W-1:0]          write_data,
	input  logic                                result_strobe,
	input  logic signed [lucf_pkg::DATA_W-1:0]  factor_value,
	input  logic [lucf_pkg::IDX_W-1:0]          row_index,
	input  logic [lucf_pkg::IDX_W-1:0]          col_index,
	input  logic [1:0]                          status_code,
	input  logic                                last_of_run,
	output int                                  pending,
	output int                                  fail_count
);

	localparam int ORDER_MAX = 8;
	localparam int FRAC = 16;
	localparam int DEPTH = ORDER_MAX * ORDER_MAX;
	localparam int DW = lucf_pkg::DATA_W;
	localparam int IW = lucf_pkg::IDX_W;

	typedef struct {
		logic signed [DW-1:0] value;
		logic [IW-1:0]        row;
		logic [IW-1:0]        col;
		logic [1:0]           status;
		logic                 last;
	} factor_entry_t;

	logic signed [DW-1:0]                 matrix[DEPTH];
	logic [lucf_pkg::COUNT_W-1:0]         loaded;
	logic [1:0]                           run_status;
	logic [lucf_pkg::SIZE_W-1:0]          size_reg;
	logic                                 cholesky;
	factor_entry_t                        expected_entries[$];

	// Keep the first fault of a run.
	function automatic void flag_fault(logic [1:0] code);
		if (run_status == lucf_pkg::STATUS_OK) run_status = code;
	endfunction

	function automatic logic signed [DW-1:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			flag_fault(lucf_pkg::STATUS_SAT);
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			flag_fault(lucf_pkg::STATUS_SAT);
			return 32'sh80000000;
		end
		return v[DW-1:0];
	endfunction

	// Rounded fixed-point product, half toward +inf.
	function automatic longint fx_mul(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
		longint p;
		p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
		return p >>> FRAC;
	endfunction

	function automatic logic signed [DW-1:0] fx_quot(logic signed [DW-1:0] a,
			logic signed [DW-1:0] p);
		if (p == 0) begin
			flag_fault(lucf_pkg::STATUS_ZERO_PIV);
			return '0;
		end
		return clamp32((longint'(a) * (longint'(1) <<< FRAC)) / longint'(p));
	endfunction

	// Floor square root, bit by bit.
	function automatic logic signed [DW-1:0] fx_root(logic signed [DW-1:0] a);
		longint unsigned v, res, bitv;
		if (a <= 0) begin
			flag_fault(lucf_pkg::STATUS_NEG_DIAG);
			return '0;
		end
		v = longint'(a) << FRAC;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[DW-1:0];
	endfunction

	// Factor the stored matrix in place and queue its n*n entries.
	function automatic void factor_matrix(int n);
		logic signed [DW-1:0] piv;
		factor_entry_t e;
		run_status = lucf_pkg::STATUS_OK;
		for (int k = 0; k < n; k++) begin
			if (cholesky) matrix[k*n+k] = fx_root(matrix[k*n+k]);
			piv = matrix[k*n+k];
			for (int i = k + 1; i < n; i++) matrix[i*n+k] = fx_quot(matrix[i*n+k], piv);
			if (cholesky)
				for (int i = k + 1; i < n; i++) matrix[k*n+i] = matrix[i*n+k];
			for (int i = k + 1; i < n; i++)
				for (int j = k + 1; j < n; j++)
					matrix[i*n+j] = clamp32(longint'(matrix[i*n+j]) - fx_mul(matrix[i*n+k],
						cholesky ? matrix[j*n+k] : matrix[k*n+j]));
		end
		for (int i = 0; i < n * n; i++) begin
			e.value = matrix[i];
			e.row = IW'(i / n);
			e.col = IW'(i % n);
			e.status = run_status;
			e.last = (i == n * n - 1);
			expected_entries.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n;
		factor_entry_t e;
		if (!arst_n) begin
			loaded = '0;
			run_status = lucf_pkg::STATUS_OK;
			size_reg = lucf_pkg::SIZE_W'(8);
			cholesky = 1'b0;
			expected_entries.delete();
			fail_count = 0;
		end else begin
			// Compare a result transfer against the oldest expectation.
			if (result_strobe) begin
				if (expected_entries.size() == 0) begin
					$error("unexpected result: value %0d row %0d col %0d",
						factor_value, row_index, col_index);
					fail_count++;
				end else begin
					e = expected_entries.pop_front();
					if (factor_value !== e.value) begin
						$error("factor_value: expected %0d, got %0d", e.value, factor_value);
						fail_count++;
					end
					if (row_index !== e.row) begin
						$error("row_index: expected %0d, got %0d", e.row, row_index);
						fail_count++;
					end
					if (col_index !== e.col) begin
						$error("col_index: expected %0d, got %0d", e.col, col_index);
						fail_count++;
					end
					if (status_code !== e.status) begin
						$error("status_code: expected %0d, got %0d", e.status, status_code);
						fail_count++;
					end
					if (last_of_run !== e.last) begin
						$error("last_of_run: expected %0d, got %0d", e.last, last_of_run);
						fail_count++;
					end
				end
			end
			// Track register writes.
			if (write_enable) begin
				if (write_index == lucf_pkg::REG_MATRIX_SIZE) size_reg = write_data;
				else cholesky = write_data[0];
			end
			// Store an element transfer; factor once the matrix is complete.
			if (start && !busy) begin
				n = (size_reg == 0) ? 1 : (size_reg > ORDER_MAX) ? ORDER_MAX : int'(size_reg);
				if (loaded < DEPTH) matrix[loaded] = element_value;
				loaded = loaded + 1'b1;
				if (int'(loaded) >= n * n) begin
					loaded = '0;
					factor_matrix(n);
				end
			end
		end
		pending = expected_entries.size();
	end

endmodule

// File: verif/lu_cholesky_factorizer_core_tb.sv
// Testbench top for the factorizer: clock, reset, stimulus and verdict.
module lu_cholesky_factorizer_core_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_TARGET = 220;
	localparam int DW = lucf_pkg::DATA_W;
	localparam int CW = lucf_pkg::CFG_W;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [DW-1:0]                element_value;
	logic                                write_enable;
	logic                                write_index;
	logic [CW-1:0]                       write_data;
	logic                                result_strobe;
	logic signed [DW-1:0]                factor_value;
	logic [lucf_pkg::IDX_W-1:0]          row_index;
	logic [lucf_pkg::IDX_W-1:0]          col_index;
	logic [1:0]                          status_code;
	logic                                last_of_run;
	int                                  pending;
	int                                  fail_count;
	int                                  cycles;
	int                                  sent;
	logic                                quiet;
	logic signed [DW-1:0]                grid[8][8];

	lu_cholesky_factorizer_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.element_value(element_value), .write_enable(write_enable),
		.write_index(write_index), .write_data(write_data),
		.result_strobe(result_strobe), .factor_value(factor_value),
		.row_index(row_index), .col_index(col_index),
		.status_code(status_code), .last_of_run(last_of_run)
	);

	lu_cholesky_factorizer_core_checker factor_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.element_value(element_value), .write_enable(write_enable),
		.write_index(write_index), .write_data(write_data),
		.result_strobe(result_strobe), .factor_value(factor_value),
		.row_index(row_index), .col_index(col_index),
		.status_code(status_code), .last_of_run(last_of_run),
		.pending(pending), .fail_count(fail_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones.
	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Transfer one element, then hold start low for a random gap.
	task automatic send_element(logic signed [DW-1:0] v);
		int g;
		start <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Wait until every queued result has come out and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CW-1:0] data);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic configure(logic [CW-1:0] size, logic mode);
		drain();
		write_reg(lucf_pkg::REG_MATRIX_SIZE, size);
		write_reg(lucf_pkg::REG_FACTOR_MODE, CW'(mode));
	endtask

	// Send one matrix: mostly well-conditioned and symmetric, sometimes raw noise.
	task automatic send_matrix(int n);
		logic noisy;
		noisy = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				if (noisy) grid[i][j] = $urandom;
				else if (i == j) grid[i][j] = n * 32'sd131072 + $urandom_range(1, 262144);
				else grid[i][j] = $signed($urandom_range(0, 262143)) - 32'sd131072;
				if ($urandom_range(0, 1) && i == j && !noisy) grid[i][j] = -grid[i][j];
				grid[j][i] = noisy ? $urandom : grid[i][j];
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) send_element(grid[i][j]);
	endtask

	initial begin
		int sz;
		logic mode;
		sent = 0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		element_value <= '0;
		write_enable <= 1'b0;
		write_index <= lucf_pkg::REG_MATRIX_SIZE;
		write_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-element LU: value extremes pass through.
		configure(4'd1, 1'b0);
		send_element(32'sh0);
		send_element(32'sh7FFFFFFF);
		send_element(32'sh80000000);
		send_element(-32'sd1);
		// Size zero acts as one; Cholesky root, non-positive diagonal, extremes.
		configure(4'd0, 1'b1);
		send_element(32'sh00010000);
		send_element(32'sh0);
		send_element(32'sh80000000);
		send_element(32'sh7FFFFFFF);
		// LU zero pivot, then a quotient that saturates.
		configure(4'd2, 1'b0);
		send_element(32'sh0);
		send_element(32'sh00010000);
		send_element(32'sh00020000);
		send_element(32'sh00030000);
		send_element(32'sh00000001);
		send_element(32'sh00000001);
		send_element(32'sh7FFFFFFF);
		send_element(32'sh0);
		// Cholesky with a trailing diagonal that goes negative.
		configure(4'd2, 1'b1);
		send_element(32'sh00040000);
		send_element(32'sh00020000);
		send_element(32'sh00020000);
		send_element(-32'sh00050000);
		// Size above the maximum acts as the maximum.
		configure(4'd15, 1'b1);
		send_matrix(8);

		// Random phases: mostly small orders, a few of the largest.
		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0, 1:    sz = 8;
				2:       sz = 0;
				3:       sz = 15;
				default: sz = $urandom_range(1, 5);
			endcase
			mode = $urandom_range(0, 1);
			configure(lucf_pkg::SIZE_W'(sz), mode);
			quiet = ($urandom_range(0, 3) == 0);
			if (sz == 0) sz = 1;
			if (sz > 8) sz = 8;
			repeat ($urandom_range(1, 3))
				if (sent < ITEM_TARGET) send_matrix(sz);
		end
		drain();

		if (fail_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
